// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FQR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FQR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/fqr_pkg.sv
package fqr_pkg;

   localparam int unsigned DataW   = 32;
   localparam int unsigned OpW     = 2;
   localparam int unsigned CountW  = 5;
   localparam int unsigned StatusW = 2;

   typedef enum logic [OpW-1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_REM = 2'd2
   } op_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic                    go;
      logic [OpW-1:0]          op;
      logic signed [DataW-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic                    valid;
      logic signed [DataW-1:0] data;
   } cell_link_type;

   typedef struct packed {
      logic                    found;
      logic signed [DataW-1:0] head_data;
      logic                    head_next_valid;
      logic signed [DataW-1:0] head_next_data;
   } chain_status_type;

endpackage

// File: rtl/core/fqr_ifs.sv
interface fqr_req_if;
   import fqr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OpW-1:0]          op;
   logic signed [DataW-1:0] value;
   modport source (output valid, output op, output value, input ready);
   modport sink (input valid, input op, input value, output ready);
endinterface

interface fqr_rsp_if;
   import fqr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] taken_value;
   logic signed [DataW-1:0] head_value;
   logic [CountW-1:0]       entry_count;
   logic                    is_empty;
   logic [StatusW-1:0]      status;
   modport source (output valid, output taken_value, output head_value, output entry_count,
                   output is_empty, output status, input ready);
   modport sink (input valid, input taken_value, input head_value, input entry_count,
                 input is_empty, input status, output ready);
endinterface

// File: rtl/core/fqr_cell.sv
module fqr_cell
   import fqr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  logic          prev_valid,
   input  logic          hit_before,
   input  cell_link_type next_link,
   output cell_link_type cur_link,
   output cell_link_type upd_link,
   output logic          match
);

   logic                    valid_ff, valid_in;
   logic signed [DataW-1:0] data_ff, data_in;
   logic                    shift, load;

   assign match = valid_ff && (data_ff == cmd.value);

   always_comb begin
      shift = 1'b0;
      load  = 1'b0;
      if (cmd.go) begin
         case (cmd.op)
            OP_ENQ:  load  = !valid_ff && prev_valid;
            OP_DEQ:  shift = 1'b1;
            OP_REM:  shift = hit_before || match;
            default: ;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (shift) begin
         valid_in = next_link.valid;
         data_in  = next_link.data;
      end else if (load) begin
         valid_in = 1'b1;
         data_in  = cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign cur_link = '{valid: valid_ff, data: data_ff};
   assign upd_link = '{valid: valid_in, data: data_in};

endmodule

// File: rtl/core/fqr_chain.sv
module fqr_chain
   import fqr_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_cmd_type     cmd,
   output chain_status_type stat,
   output logic [DEPTH-1:0] valid_vec
);

   cell_link_type cur [DEPTH];
   cell_link_type upd [DEPTH];
   logic [DEPTH:0] hit;
   logic [DEPTH-1:0] match;

   assign hit[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_link_type next_link;
      logic          prev_valid;

      if (i == DEPTH - 1) begin : g_last
         assign next_link = '0;
      end else begin : g_mid
         assign next_link = cur[i+1];
      end

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = cur[i-1].valid;
      end

      fqr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_valid (prev_valid),
         .hit_before (hit[i]),
         .next_link  (next_link),
         .cur_link   (cur[i]),
         .upd_link   (upd[i]),
         .match      (match[i])
      );

      assign hit[i+1]     = hit[i] | match[i];
      assign valid_vec[i] = cur[i].valid;
   end

   assign stat.found           = hit[DEPTH];
   assign stat.head_data       = cur[0].data;
   assign stat.head_next_valid = upd[0].valid;
   assign stat.head_next_data  = upd[0].data;

endmodule

// File: rtl/core/fifo_queue_with_remove.sv
// The response is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; enqueue, dequeue and remove each finish in one
// pass of the cell row, with a parallel compare and prefix in every cell for remove.
// A stalled response blocks new requests only while its output register is full.
// Reset (synchronous, active high) empties the queue and drops any pending response.
`include "assert_macros.svh"

module fifo_queue_with_remove
   import fqr_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   fqr_req_if.sink        req_bus,
   fqr_rsp_if.source      rsp_bus
);

   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);

   logic                    go;
   cell_cmd_type            cmd;
   chain_status_type        stat;
   logic [DEPTH-1:0]        valid_vec;

   logic [CntW-1:0]         count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DataW-1:0] taken_ff, taken_in;
   logic signed [DataW-1:0] head_ff, head_in;
   logic [CountW-1:0]       ecount_ff, ecount_in;
   logic                    empty_ff, empty_in;
   status_type              status_ff, status_in;
   logic [CntW+CountW-1:0]  count_wide;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign go            = req_bus.valid && req_bus.ready;
   assign cmd           = '{go: go, op: req_bus.op, value: req_bus.value};

   fqr_chain #(.DEPTH(DEPTH)) u_chain (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .valid_vec (valid_vec)
   );

   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      taken_in  = '0;
      case (req_bus.op)
         OP_ENQ: begin
            if (count_ff == FullCount) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CntW'(1);
            end
         end
         OP_DEQ: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CntW'(1);
               taken_in = stat.head_data;
            end
         end
         OP_REM: begin
            if (stat.found) begin
               count_in = count_ff - CntW'(1);
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         default: ;
      endcase
   end

   assign count_wide   = {{CountW{1'b0}}, count_in};
   assign ecount_in    = count_wide[CountW-1:0];
   assign empty_in     = (count_in == '0);
   assign head_in      = stat.head_next_valid ? stat.head_next_data : '0;
   assign rsp_valid_in = go || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            count_ff <= count_in;
         end
      end
      if (go) begin
         taken_ff  <= taken_in;
         head_ff   <= head_in;
         ecount_ff <= ecount_in;
         empty_ff  <= empty_in;
         status_ff <= status_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.taken_value = taken_ff;
   assign rsp_bus.head_value  = head_ff;
   assign rsp_bus.entry_count = ecount_ff;
   assign rsp_bus.is_empty    = empty_ff;
   assign rsp_bus.status      = status_ff;

   `FQR_ASSERT_NOW(a_count_matches_cells, clock, reset, 1'b1,
                   $countones(valid_vec) == 32'(count_ff), "count disagrees with cells")
   `FQR_ASSERT_NOW(a_cells_packed, clock, reset, 1'b1,
                   ((valid_vec + 1'b1) & valid_vec) == '0, "hole in cell row")
   `FQR_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
                   count_ff <= FullCount, "count above depth")
   `FQR_ASSERT_NEXT(a_deq_drops_one, clock, reset,
                    go && (req_bus.op == OP_DEQ) && (count_ff != '0),
                    count_ff == $past(count_ff) - CntW'(1), "dequeue did not drop one")
   `FQR_ASSERT_NEXT(a_full_enq_holds, clock, reset,
                    go && (req_bus.op == OP_ENQ) && (count_ff == FullCount),
                    count_ff == FullCount, "enqueue on full changed count")

endmodule
